>>> hdl/apd_pkg.sv
// shared constants and codes for the allelic profile distance block
package apd_pkg;

  localparam int STRAINS  = 64;
  localparam int LOCI     = 256;
  localparam int STRAIN_W = $clog2(STRAINS);
  localparam int LOCUS_W  = $clog2(LOCI);
  localparam int ADDR_W   = STRAIN_W + LOCUS_W;
  localparam int DEPTH    = STRAINS * LOCI;
  localparam int ALLELE_W = 32;
  localparam int COUNT_W  = 9;
  localparam int CFG_W    = 9;

  // input action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // configuration register indexes
  localparam logic REG_MISSING_MODE = 1'b0;
  localparam logic REG_LOCI_IN_USE  = 1'b1;

  // missing data modes
  localparam logic [1:0] MODE_IGNORE        = 2'd0;
  localparam logic [1:0] MODE_REMOVE_COLUMN = 2'd1;
  localparam logic [1:0] MODE_AS_ALLELE     = 2'd2;
  localparam logic [1:0] MODE_ABSOLUTE      = 2'd3;

  localparam logic [COUNT_W-1:0] LOCI_MAX = COUNT_W'(LOCI);

endpackage

>>> hdl/allelic_profile_distance.sv
// top level: allele profile store with pairwise distance queries
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | action, strain, locus, allele, other_strain
//  out     | out_valid / out_ready| differences
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a write transaction leaves the block ready again at once.
// a query, n = min(loci_in_use, LOCI), runs in steps: the accepting cycle, then the
// n locus pairs read one after another from the two read ports of the allele
// memory, the last compare after the read latency, and the load of the result.
// with zero loci in use a query skips the reads and returns zero.
// reset clears control state only; the allele memory is undefined until written.
// a finished result may wait in the output register while writes and the next query
// are taken; a second finished result then holds the engine and the input until the
// first one leaves.
module allelic_profile_distance (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [apd_pkg::STRAIN_W-1:0]  strain,
  input  logic [apd_pkg::LOCUS_W-1:0]   locus,
  input  logic signed [apd_pkg::ALLELE_W-1:0] allele,
  input  logic [apd_pkg::STRAIN_W-1:0]  other_strain,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [apd_pkg::COUNT_W-1:0]   differences,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [apd_pkg::CFG_W-1:0]     cfg_data
);
  import apd_pkg::*;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // taking transactions
  localparam logic [1:0] S_READ = 2'd1;  // issuing one locus pair per cycle
  localparam logic [1:0] S_WAIT = 2'd2;  // last pair in flight
  localparam logic [1:0] S_HOLD = 2'd3;  // count final, waiting for output slot

  logic [1:0] state;

  // configuration registers
  logic [1:0]         missing_mode;
  logic [COUNT_W-1:0] loci_in_use;

  // query context
  logic [STRAIN_W-1:0] strain_a;
  logic [STRAIN_W-1:0] strain_b;
  logic [LOCUS_W-1:0]  k;
  logic [LOCUS_W-1:0]  last_k;
  logic [COUNT_W-1:0]  count;

  // read pipeline tags, aligned with the registered memory data
  logic rd_vld;
  logic rd_last;

  // allele memory: one write port, two read ports with registered data
  logic [ALLELE_W-1:0] mem [0:DEPTH-1];
  logic [ALLELE_W-1:0] rd_a;
  logic [ALLELE_W-1:0] rd_b;

  logic               in_acc;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  addr_a;
  logic [ADDR_W-1:0]  addr_b;
  logic [COUNT_W-1:0] n_sat;
  logic [COUNT_W-1:0] n_m1;
  logic               miss_a;
  logic               miss_b;
  logic               diff;
  logic               out_free;
  logic               load_out;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign wr_en     = in_acc && (action == ACT_WRITE);
  assign wr_addr   = {strain, locus};
  assign addr_a    = {strain_a, k};
  assign addr_b    = {strain_b, k};
  assign out_free  = !out_valid || out_ready;
  assign load_out  = (state == S_HOLD) && out_free;

  // loci in use saturates at the number of loci per strain (LOCI)
  assign n_sat = (loci_in_use > LOCI_MAX) ? LOCI_MAX : loci_in_use;
  assign n_m1  = n_sat - COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= allele;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  // zero or negative allele means missing
  assign miss_a = (rd_a == '0) || rd_a[ALLELE_W-1];
  assign miss_b = (rd_b == '0) || rd_b[ALLELE_W-1];

  always_comb begin
    if (!miss_a && !miss_b) begin
      diff = (rd_a != rd_b);
    end else begin
      case (missing_mode)
        MODE_AS_ALLELE: diff = !(miss_a && miss_b);
        MODE_ABSOLUTE:  diff = 1'b1;
        default:        diff = 1'b0;  // ignore and remove column skip the locus
      endcase
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      missing_mode <= MODE_IGNORE;
      loci_in_use  <= LOCI_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MISSING_MODE: missing_mode <= cfg_data[1:0];
        REG_LOCI_IN_USE:  loci_in_use  <= cfg_data;
        default: ;
      endcase
    end
  end

  // query sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_vld    <= 1'b0;
      rd_last   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld    <= (state == S_READ);
      rd_last   <= (state == S_READ) && (k == last_k);
      // result register fills from the engine, drains on out_ready
      out_valid <= load_out || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (in_acc && (action == ACT_QUERY)) begin
            // zero loci in use: nothing to compare, result is zero
            state <= (n_sat == '0) ? S_HOLD : S_READ;
          end
        end
        S_READ: begin
          if (k == last_k) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (rd_vld && rd_last) begin
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // query datapath
  always_ff @(posedge clk) begin
    if (in_acc && (action == ACT_QUERY)) begin
      strain_a <= strain;
      strain_b <= other_strain;
      k        <= '0;
      last_k   <= n_m1[LOCUS_W-1:0];
      count    <= '0;
    end else begin
      if (state == S_READ) begin
        k <= k + LOCUS_W'(1);
      end
      if (rd_vld) begin
        count <= count + COUNT_W'(diff);
      end
    end
    if (load_out) begin
      differences <= count;
    end
  end

endmodule

>>> hdl/apd_checker.sv
// port level checks for the allelic profile distance block, with bind
module apd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        action,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [apd_pkg::COUNT_W-1:0] differences
);
  import apd_pkg::*;

  // after a query transaction the input is not ready in the following cycle
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (action == ACT_QUERY)) |=> !in_ready)
    else $error("input ready right after a query transaction");

  // a write transaction leaves the block ready
  a_write_ready: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (action == ACT_WRITE)) |=> in_ready)
    else $error("input not ready after a write transaction");

  // a count never exceeds the number of loci
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (differences <= LOCI_MAX))
    else $error("difference count beyond loci");

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(differences)))
    else $error("result changed while stalled");

endmodule

bind allelic_profile_distance apd_checker u_apd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .action      (action),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .differences (differences)
);

>>> bench/allelic_profile_distance_test.sv
// testbench for the allele profile store: random writes and distance queries checked against a predictor
module allelic_profile_distance_test;
  import apd_pkg::*;

  // one transaction on the input channel, either an allele write or a pair query
  typedef struct {
    logic                       action;
    logic [STRAIN_W-1:0]        strain;
    logic [LOCUS_W-1:0]         locus;
    logic signed [ALLELE_W-1:0] allele;
    logic [STRAIN_W-1:0]        other;
  } profile_op_t;

  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 70;
  localparam int LONG_STALL  = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       action = ACT_WRITE;
  logic [STRAIN_W-1:0]        strain = '0;
  logic [LOCUS_W-1:0]         locus = '0;
  logic signed [ALLELE_W-1:0] allele = '0;
  logic [STRAIN_W-1:0]        other_strain = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [COUNT_W-1:0]         differences;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic                       cfg_index = REG_MISSING_MODE;
  logic [CFG_W-1:0]           cfg_data = '0;

  allelic_profile_distance dut (.*);

  always #4 clk = ~clk;

  // predictor state: its own copy of the allele store and of both registers
  logic signed [ALLELE_W-1:0] allele_mem [STRAINS][LOCI];
  logic [1:0]                 missing_policy = MODE_IGNORE;
  logic [CFG_W-1:0]           loci_span = CFG_W'(LOCI);
  logic [COUNT_W-1:0]         expected_diffs [$];

  // generator side: which entries will have been written by the time a query is sent,
  // so that no query ever walks into an entry that was never written
  bit          gen_written [STRAINS][LOCI];
  profile_op_t pending_ops [$];
  int          items_queued = 0;
  int          items_sent = 0;

  profile_op_t        cur_op;
  int                 tx_hold = 0;
  int                 tx_calm = 0;
  int                 rx_hold = 0;
  int                 rx_calm = 0;
  int                 rx_gap;
  int                 results_seen = 0;
  int                 stall_left = 0;
  bit                 stall_done = 1'b0;
  int                 mismatches = 0;
  logic [COUNT_W-1:0] want_diff;

  logic [1:0] mode_order [4] = '{MODE_IGNORE, MODE_REMOVE_COLUMN, MODE_AS_ALLELE, MODE_ABSOLUTE};
  // a mix of short walks, the full store, and values past the store that must saturate
  int span_order [PHASES] = '{4, 1, 16, 256, 2, 9, 511, 12, 3, 300, 7, 256};

  // expected count of differing loci for a strain pair under the current registers
  function automatic logic [COUNT_W-1:0] count_differences(input logic [STRAIN_W-1:0] sa,
                                                           input logic [STRAIN_W-1:0] sb);
    int n;
    int total;
    logic signed [ALLELE_W-1:0] a;
    logic signed [ALLELE_W-1:0] b;
    bit ma;
    bit mb;
    n = (loci_span > LOCI) ? LOCI : loci_span;
    total = 0;
    for (int k = 0; k < n; k++) begin
      a = allele_mem[sa][k];
      b = allele_mem[sb][k];
      // zero and every negative number stand for a missing allele
      ma = (a <= 0);
      mb = (b <= 0);
      if (ma || mb) begin
        if (missing_policy == MODE_AS_ALLELE) begin
          if (!(ma && mb)) total++;
        end else if (missing_policy == MODE_ABSOLUTE) begin
          total++;
        end
        // ignore and remove-column both skip the locus
      end else if (a != b) begin
        total++;
      end
    end
    return COUNT_W'(total);
  endfunction

  // alleles lean on a few small numbers so that equal pairs are common,
  // with the missing forms and both extremes mixed in
  function automatic logic signed [ALLELE_W-1:0] pick_allele();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return 0 - int'($urandom_range(1, 3));
      2:       return 32'sh8000_0000;
      3:       return 32'sh7fff_ffff;
      4, 5:    return $urandom;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  function automatic void push_write(input int s, input int l, input logic signed [ALLELE_W-1:0] a);
    profile_op_t op;
    op.action = ACT_WRITE;
    op.strain = STRAIN_W'(s);
    op.locus  = LOCUS_W'(l);
    op.allele = a;
    op.other  = STRAIN_W'($urandom_range(0, STRAINS - 1));
    pending_ops.push_back(op);
    gen_written[s][l] = 1'b1;
    items_queued++;
  endfunction

  // locus and allele are don't-care on a query and carry noise
  function automatic void push_query(input int s, input int o);
    profile_op_t op;
    op.action = ACT_QUERY;
    op.strain = STRAIN_W'(s);
    op.locus  = LOCUS_W'($urandom_range(0, LOCI - 1));
    op.allele = $urandom;
    op.other  = STRAIN_W'(o);
    pending_ops.push_back(op);
    items_queued++;
  endfunction

  function automatic bit strain_ready(input int s, input int n);
    for (int k = 0; k < n; k++) if (!gen_written[s][k]) return 1'b0;
    return 1'b1;
  endfunction

  // a gap in cycles before the next transaction, with runs of back-to-back traffic
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 15);
  endfunction

  // idle means: everything queued was taken, no result outstanding, and a few
  // extra cycles for a trailing write that produces no result
  task automatic wait_idle(input int tail);
    do @(posedge clk); while (items_sent != items_queued || expected_diffs.size() != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_reg(input logic idx, input logic [CFG_W-1:0] value);
    wait_idle(8);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_MISSING_MODE) missing_policy = value[1:0];
    else loci_span = value;
  endtask

  // unused upper bits of the mode write carry random junk
  task automatic set_mode(input logic [1:0] m);
    logic [CFG_W-1:0] v;
    v = CFG_W'($urandom_range(0, 2**CFG_W - 1));
    v[1:0] = m;
    set_reg(REG_MISSING_MODE, v);
  endtask

  task automatic random_phase(input logic [1:0] m, input int span_cfg, input int count);
    int n;
    int want;
    int s;
    int r;
    int pool [$];
    set_mode(m);
    set_reg(REG_LOCI_IN_USE, CFG_W'(span_cfg));
    n = (span_cfg > LOCI) ? LOCI : span_cfg;
    want = (n > 32) ? 2 : 4;
    // fill whole profiles until enough strains can be queried at this walk length
    do begin
      pool.delete();
      for (int i = 0; i < STRAINS; i++) if (strain_ready(i, n)) pool.push_back(i);
      if (pool.size() < want) begin
        s = $urandom_range(0, STRAINS - 1);
        for (int k = 0; k < n; k++) if (!gen_written[s][k]) push_write(s, k, pick_allele());
      end
    end while (pool.size() < want);
    repeat (count) begin
      r = $urandom_range(0, 9);
      if (r < 4)
        push_query(pool[$urandom_range(0, pool.size() - 1)],
                   pool[$urandom_range(0, pool.size() - 1)]);
      else if (r < 8)
        push_write(pool[$urandom_range(0, pool.size() - 1)], $urandom_range(0, n - 1),
                   pick_allele());
      else
        push_write($urandom_range(0, STRAINS - 1), $urandom_range(0, LOCI - 1), pick_allele());
    end
  endtask

  // driver: one transaction at a time from the pending queue, with random gaps;
  // the predictor is updated at the edge where a transaction is accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_hold  <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (cur_op.action == ACT_WRITE)
          allele_mem[cur_op.strain][cur_op.locus] = cur_op.allele;
        else
          expected_diffs.push_back(count_differences(cur_op.strain, cur_op.other));
        items_sent++;
      end
      // the slot is free when nothing is offered or the offer was just taken
      if (!in_valid || in_ready) begin
        if (tx_hold == 0 && pending_ops.size() != 0) begin
          cur_op = pending_ops.pop_front();
          action       <= cur_op.action;
          strain       <= cur_op.strain;
          locus        <= cur_op.locus;
          allele       <= cur_op.allele;
          other_strain <= cur_op.other;
          in_valid     <= 1'b1;
          tx_hold      <= draw_gap(tx_calm);
        end else begin
          in_valid <= 1'b0;
          if (tx_hold != 0) tx_hold <= tx_hold - 1;
        end
      end
    end
  end

  // one long hold-off on the result side: the sender keeps offering writes and
  // queries, so the block ends up with a finished result and a stalled input
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (!stall_done && results_seen == 20) begin
      stall_left <= LONG_STALL;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready    <= 1'b0;
      rx_hold      <= 0;
      results_seen <= 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_diffs.size() == 0) begin
          $display("%0t: result with nothing pending, expected none, actual %0d",
                   $time, differences);
          mismatches++;
        end else begin
          want_diff = expected_diffs.pop_front();
          if (differences !== want_diff) begin
            $display("%0t: differences mismatch, expected %0d, actual %0d",
                     $time, want_diff, differences);
            mismatches++;
          end
        end
        rx_gap = draw_gap(rx_calm);
        rx_hold   <= rx_gap;
        out_ready <= (rx_gap == 0 && stall_left == 0);
      end else if (rx_hold != 0) begin
        rx_hold   <= rx_hold - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (stall_left == 0);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed part: two loci per walk so that every profile used is short.
    // strain 0 holds the top allele and a small one, strain 63 the top allele
    // and the sign bit alone (missing), strain 1 zero (missing) and a present
    // value, strain 2 two negative alleles so that both sides can be missing
    set_reg(REG_LOCI_IN_USE, CFG_W'(2));
    push_write(0, 0, 32'sh7fff_ffff);
    push_write(0, 1, 1);
    push_write(63, 0, 32'sh7fff_ffff);
    push_write(63, 1, 32'sh8000_0000);
    push_write(1, 0, 0);
    push_write(1, 1, 5);
    push_write(2, 0, -1);
    push_write(2, 1, -7);
    push_write(63, LOCI - 1, 3);
    // the same pairs under every missing-data policy
    for (int i = 0; i < 4; i++) begin
      set_mode(mode_order[i]);
      push_query(0, 63);
      push_query(1, 2);
      push_query(0, 1);
    end
    // an empty walk answers zero and reads nothing, not even unwritten strains
    set_reg(REG_LOCI_IN_USE, '0);
    push_query(5, 9);

    // random part: each policy at short walks, the full store and saturated counts
    for (int p = 0; p < PHASES; p++)
      random_phase(mode_order[p % 4], span_order[p], PHASE_ITEMS);

    // a query can take a full walk, so leave room for any stray result
    wait_idle(LOCI + 16);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  // guard against a hang: far beyond the slowest legal run
  initial begin
    #8000000;
    $display("%0t: timeout, %0d of %0d transactions sent, %0d results outstanding",
             $time, items_sent, items_queued, expected_diffs.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> sim.f
hdl/apd_pkg.sv
hdl/allelic_profile_distance.sv
hdl/apd_checker.sv
bench/allelic_profile_distance_test.sv
